### hw/rtl/ptdt_pkg.sv
// ----------------------------------------------------------------------------
// ptdt_pkg
// Shared types and codes for the periodic task dispatch table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptdt_pkg;

	localparam int TASK_SLOTS_DEF = 8;

	localparam int CMD_W    = 3;
	localparam int ID_W     = 8;
	localparam int PERIOD_W = 16;
	localparam int DELAY_W  = 17;
	localparam int STEP_W   = 10;
	localparam int KIND_W   = 2;
	localparam int SIDX_W   = 3;
	localparam int STAT_W   = 3;
	localparam int SST_W    = 2;

	// commands
	localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SUSPEND = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_STATUS  = 3'd5;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ACK    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd3;

	// slot states as stored
	localparam logic [SST_W-1:0] SST_READY     = 2'd0;
	localparam logic [SST_W-1:0] SST_SUSPENDED = 2'd2;
	localparam logic [SST_W-1:0] SST_STOPPED   = 2'd3;

	// reported status codes
	localparam logic [STAT_W-1:0] STAT_READY     = 3'd0;
	localparam logic [STAT_W-1:0] STAT_RUNNING   = 3'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic [ID_W-1:0]          id;
		logic [PERIOD_W-1:0]      period;
		logic signed [DELAY_W-1:0] delay;
		logic [SST_W-1:0]         st;
	} slot_t;

	typedef struct packed {
		logic  hit;     // slot produces a result (fire, free slot for add, or id match)
		logic  wr_en;   // slot entry must be written back
		slot_t wr_slot;
	} slot_eval_t;

endpackage

`default_nettype wire

### hw/rtl/periodic_task_dispatch_table_core.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatch_table_core
// Time-triggered task table: tick scan, add/delete/suspend/resume, status.
// ----------------------------------------------------------------------------
// Usage:
//  - A command transaction is taken at a clock edge with start high and busy
//    low; cmd, task_id, period and first_delay are sampled there.
//  - Results leave at most one per cycle, each marked by a single-cycle
//    strobe; the receiver cannot stall, so every strobed transaction must be
//    taken. last flags the final result of a command.
//  - The table is scanned one slot per cycle through a registered read of
//    the slot store; a single subtractor updates delays as the scan walks.
//    A tick visits every slot and gives one fire result per due slot in
//    ready state plus a closing tick-done result.
//    Add, delete, suspend, resume and status stop at the first hit; when
//    nothing matches, the scan visits every slot and closes with a result.
//    Unknown commands answer on the next cycle with ok low.
//  - busy is high from the accepting edge up to the edge that loads the
//    final result; an unknown command never raises it.
//  - Write tick_step via cfg_we / cfg_wdata only while idle (left to the user).
//  - Reset clears the control state and per-slot valid bits; a slot never
//    written reads as id 0, period 0, delay 0, stopped. No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_dispatch_table_core #(
	parameter int TASK_SLOTS = ptdt_pkg::TASK_SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_we,
	input  wire logic [ptdt_pkg::STEP_W-1:0]   cfg_wdata,
	// command
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [ptdt_pkg::CMD_W-1:0]    cmd,
	input  wire logic [ptdt_pkg::ID_W-1:0]     task_id,
	input  wire logic [ptdt_pkg::PERIOD_W-1:0] period,
	input  wire logic [ptdt_pkg::PERIOD_W-1:0] first_delay,
	// results
	output logic                               strobe,
	output logic [ptdt_pkg::KIND_W-1:0]        kind,
	output logic [ptdt_pkg::ID_W-1:0]          fired_id,
	output logic [ptdt_pkg::SIDX_W-1:0]        slot_index,
	output logic                               ok,
	output logic [ptdt_pkg::STAT_W-1:0]        task_status,
	output logic                               last
);

	localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W = $clog2(TASK_SLOTS + 1);
	localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(TASK_SLOTS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_t;

	state_t                          state_q;
	logic [ptdt_pkg::STEP_W-1:0]     tick_step_q;

	// latched command
	logic [ptdt_pkg::CMD_W-1:0]      cmd_q;
	logic [ptdt_pkg::ID_W-1:0]       id_q;
	logic [ptdt_pkg::PERIOD_W-1:0]   period_q;
	logic [ptdt_pkg::PERIOD_W-1:0]   idelay_q;

	// scan issue side
	logic [CNT_W-1:0]                scan_idx_q;
	logic                            iss_q;

	// read stage
	logic                            act_s1;
	logic                            last_s1;
	logic [IDX_W-1:0]                idx_s1;
	logic                            rd_vld_s1;
	ptdt_pkg::slot_t                 rd_slot_s1;

	// slot store and its valid bits
	ptdt_pkg::slot_t                 mem_q [TASK_SLOTS];
	logic [TASK_SLOTS-1:0]           vld_q;

	ptdt_pkg::slot_t                 entry;
	ptdt_pkg::slot_eval_t            eval;
	logic                            wr_en;
	logic [IDX_W-1:0]                rd_addr;

	// registered outputs
	logic                            strobe_q;
	logic [ptdt_pkg::KIND_W-1:0]     kind_q;
	logic [ptdt_pkg::ID_W-1:0]       fired_id_q;
	logic [ptdt_pkg::SIDX_W-1:0]     slot_index_q;
	logic                            ok_q;
	logic [ptdt_pkg::STAT_W-1:0]     task_status_q;
	logic                            last_q;

	assign rd_addr = scan_idx_q[IDX_W-1:0];

	// never-written slots read as the reset entry
	always_comb begin
		if (rd_vld_s1) begin
			entry = rd_slot_s1;
		end else begin
			entry        = '0;
			entry.st     = ptdt_pkg::SST_STOPPED;
		end
	end

	ptdt_slot_eval u_eval (
		.cmd           (cmd_q),
		.task_id       (id_q),
		.period        (period_q),
		.first_delay   (idelay_q),
		.tick_step     (tick_step_q),
		.entry         (entry),
		.eval          (eval)
	);

	assign wr_en = (state_q == S_SCAN) && act_s1 && eval.wr_en;

	// slot store: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[idx_s1] <= eval.wr_slot;
		rd_slot_s1 <= mem_q[rd_addr];
	end

	// tick_step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_step_q <= ptdt_pkg::STEP_W'(1);
		end else if (cfg_we) begin
			tick_step_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cmd_q         <= '0;
			id_q          <= '0;
			period_q      <= '0;
			idelay_q      <= '0;
			scan_idx_q    <= '0;
			iss_q         <= 1'b0;
			act_s1        <= 1'b0;
			last_s1       <= 1'b0;
			idx_s1        <= '0;
			rd_vld_s1     <= 1'b0;
			vld_q         <= '0;
			strobe_q      <= 1'b0;
			kind_q        <= '0;
			fired_id_q    <= '0;
			slot_index_q  <= '0;
			ok_q          <= 1'b0;
			task_status_q <= '0;
			last_q        <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (wr_en)
				vld_q[idx_s1] <= 1'b1;

			case (state_q)
				S_IDLE: begin
					act_s1 <= 1'b0;
					if (start) begin
						cmd_q      <= cmd;
						id_q       <= task_id;
						period_q   <= period;
						idelay_q   <= first_delay;
						scan_idx_q <= '0;
						if (cmd > ptdt_pkg::CMD_STATUS) begin
							// unknown command: plain ack with ok low
							strobe_q      <= 1'b1;
							kind_q        <= ptdt_pkg::KIND_ACK;
							fired_id_q    <= '0;
							slot_index_q  <= '0;
							ok_q          <= 1'b0;
							task_status_q <= ptdt_pkg::STAT_READY;
							last_q        <= 1'b1;
						end else begin
							iss_q   <= 1'b1;
							state_q <= S_SCAN;
						end
					end
				end

				S_SCAN: begin
					// issue the read of the next slot
					act_s1    <= iss_q;
					last_s1   <= (scan_idx_q == LAST_SLOT);
					idx_s1    <= rd_addr;
					rd_vld_s1 <= vld_q[rd_addr];
					if (iss_q) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
						if (scan_idx_q == LAST_SLOT)
							iss_q <= 1'b0;
					end

					// evaluate the slot read last cycle
					if (act_s1) begin
						if (eval.hit) begin
							strobe_q     <= 1'b1;
							slot_index_q <= ptdt_pkg::SIDX_W'(idx_s1);
							case (cmd_q)
								ptdt_pkg::CMD_TICK: begin
									kind_q        <= ptdt_pkg::KIND_FIRE;
									fired_id_q    <= entry.id;
									ok_q          <= 1'b0;
									task_status_q <= ptdt_pkg::STAT_RUNNING;
									last_q        <= 1'b0;
								end
								ptdt_pkg::CMD_STATUS: begin
									kind_q        <= ptdt_pkg::KIND_STATUS;
									fired_id_q    <= id_q;
									ok_q          <= 1'b1;
									task_status_q <= ptdt_pkg::STAT_W'(entry.st);
									last_q        <= 1'b1;
								end
								default: begin
									kind_q        <= ptdt_pkg::KIND_ACK;
									fired_id_q    <= '0;
									ok_q          <= 1'b1;
									task_status_q <= ptdt_pkg::STAT_READY;
									last_q        <= 1'b1;
								end
							endcase
						end
						if (eval.hit && (cmd_q != ptdt_pkg::CMD_TICK)) begin
							// first hit ends the search
							act_s1  <= 1'b0;
							iss_q   <= 1'b0;
							state_q <= S_IDLE;
						end else if (last_s1) begin
							act_s1  <= 1'b0;
							state_q <= S_FIN;
						end
					end
				end

				S_FIN: begin
					strobe_q     <= 1'b1;
					slot_index_q <= '0;
					ok_q         <= 1'b0;
					last_q       <= 1'b1;
					case (cmd_q)
						ptdt_pkg::CMD_TICK: begin
							kind_q        <= ptdt_pkg::KIND_DONE;
							fired_id_q    <= '0;
							task_status_q <= ptdt_pkg::STAT_READY;
						end
						ptdt_pkg::CMD_STATUS: begin
							kind_q        <= ptdt_pkg::KIND_STATUS;
							fired_id_q    <= id_q;
							task_status_q <= ptdt_pkg::STAT_NOT_FOUND;
						end
						default: begin
							kind_q        <= ptdt_pkg::KIND_ACK;
							fired_id_q    <= '0;
							task_status_q <= ptdt_pkg::STAT_READY;
						end
					endcase
					state_q <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign strobe      = strobe_q;
	assign kind        = kind_q;
	assign fired_id    = fired_id_q;
	assign slot_index  = slot_index_q;
	assign ok          = ok_q;
	assign task_status = task_status_q;
	assign last        = last_q;

endmodule

`default_nettype wire

### hw/rtl/ptdt_slot_eval.sv
// ----------------------------------------------------------------------------
// ptdt_slot_eval
// Per-slot decision and the shared delay subtractor used in tick scans.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptdt_slot_eval (
	input  wire logic [ptdt_pkg::CMD_W-1:0]    cmd,
	input  wire logic [ptdt_pkg::ID_W-1:0]     task_id,
	input  wire logic [ptdt_pkg::PERIOD_W-1:0] period,
	input  wire logic [ptdt_pkg::PERIOD_W-1:0] first_delay,
	input  wire logic [ptdt_pkg::STEP_W-1:0]   tick_step,
	input  wire ptdt_pkg::slot_t               entry,
	output ptdt_pkg::slot_eval_t               eval
);

	logic                                 due;
	logic [ptdt_pkg::DELAY_W-1:0]         sub_a;
	logic [ptdt_pkg::DELAY_W-1:0]         sub_y;
	logic                                 id_match;

	// delay <= 0 -> fire and reload from period
	assign due   = entry.delay[ptdt_pkg::DELAY_W-1] || (entry.delay == '0);
	assign sub_a = due ? {1'b0, entry.period} : entry.delay;
	assign sub_y = sub_a - {{(ptdt_pkg::DELAY_W-ptdt_pkg::STEP_W){1'b0}}, tick_step};
	assign id_match = (entry.id == task_id);

	always_comb begin
		eval         = '0;
		eval.wr_slot = entry;
		case (cmd)
			ptdt_pkg::CMD_TICK: begin
				if (entry.st == ptdt_pkg::SST_READY) begin
					eval.wr_en         = 1'b1;
					eval.hit           = due;
					eval.wr_slot.delay = sub_y;
				end
			end
			ptdt_pkg::CMD_ADD: begin
				if (entry.st == ptdt_pkg::SST_STOPPED) begin
					eval.hit            = 1'b1;
					eval.wr_en          = 1'b1;
					eval.wr_slot.id     = task_id;
					eval.wr_slot.period = period;
					eval.wr_slot.delay  = {1'b0, first_delay};
					eval.wr_slot.st     = ptdt_pkg::SST_READY;
				end
			end
			ptdt_pkg::CMD_DELETE, ptdt_pkg::CMD_SUSPEND, ptdt_pkg::CMD_RESUME: begin
				if (id_match) begin
					eval.hit   = 1'b1;
					eval.wr_en = 1'b1;
					if (cmd == ptdt_pkg::CMD_DELETE)
						eval.wr_slot.st = ptdt_pkg::SST_STOPPED;
					else if (cmd == ptdt_pkg::CMD_SUSPEND)
						eval.wr_slot.st = ptdt_pkg::SST_SUSPENDED;
					else
						eval.wr_slot.st = ptdt_pkg::SST_READY;
				end
			end
			ptdt_pkg::CMD_STATUS: begin
				eval.hit = id_match;
			end
			default: begin
				eval.hit = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire
